/* hw/rtl/htenc_pkg.sv */
package htenc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned IN_CODE_W  = 32;
  localparam int unsigned IN_LEN_W   = 6;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned M_TUSER_W  = 3;

  localparam int unsigned SYM_LSB    = 0;
  localparam int unsigned CODE_LSB   = SYM_LSB + SYM_W;
  localparam int unsigned LEN_LSB    = CODE_LSB + IN_CODE_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_ENCODE = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_BYTE  = 2'd0,
    STAT_UNDEF = 2'd1,
    STAT_OVFL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PACK,
    ST_FAULT
  } state_e;

endpackage

/* hw/rtl/huffman_table_encoder_top.sv */
// Load request: the table entry is written at the accepting edge.
// Encode request: the accepting cycle, the table read state, then either the packer
// state, which emits the results, or the fault state; a dropped encode request stays idle.
// Output stalls hold the packer and fault states. A new request is accepted only once the
// previous one is back in idle. Reset clears the entry valid bits (the table then reads
// as no codes), the message state and the output register, and sets output_limit to 65535.
module huffman_table_encoder_top #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [htenc_pkg::LIMIT_W-1:0]      cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // symbol[7:0], code_bits[39:8], code_length[45:40], zero[47:46]
  input  logic [htenc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // command[0]
  input  logic                               s_axis_tuser,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_byte[7:0]
  output logic [htenc_pkg::BYTE_W-1:0]       m_axis_tdata,
  // status[1:0], end_of_message[2]
  output logic [htenc_pkg::M_TUSER_W-1:0]    m_axis_tuser,
  output logic                               m_axis_tlast
);

  import htenc_pkg::*;

  localparam int unsigned AW    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned MEM_W = MAX_CODE_LEN + LEN_W;
  localparam int unsigned SH_W  = MAX_CODE_LEN + BYTE_W;
  localparam int unsigned SHA_W = $clog2(SH_W + 1);

  state_e state_q, state_d;

  logic [LIMIT_W-1:0]      limit_q;
  logic [SYMBOL_COUNT-1:0] valid_q, valid_d;
  logic [SH_W-1:0]         sh_q, sh_d;
  logic [SHA_W-1:0]        rem_q, rem_d;
  logic [LIMIT_W-1:0]      bytes_q, bytes_d;
  logic                    err_q, err_d;
  logic                    last_q, last_d;
  logic                    oob_q, oob_d;
  logic                    rd_valid_q, rd_valid_d;
  status_e                 fault_q, fault_d;

  logic                    out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]       out_byte_q, out_byte_d;
  status_e                 out_stat_q, out_stat_d;
  logic                    out_eom_q, out_eom_d;
  logic                    out_lor_q, out_lor_d;

  logic                    in_fire;
  logic                    slot_free;
  logic [SYM_W-1:0]        in_sym;
  logic [IN_LEN_W-1:0]     in_len;
  logic [LEN_W-1:0]        len_sat;
  logic [MAX_CODE_LEN-1:0] code_mask;
  logic                    in_oob;

  logic                    mem_we, mem_re;
  logic [MEM_W-1:0]        mem_wdata, mem_rdata;
  logic [AW-1:0]           mem_addr;

  logic [LEN_W-1:0]        rd_len;
  logic [MAX_CODE_LEN-1:0] rd_code;
  logic [SHA_W-1:0]        sh_amt;
  logic [SHA_W-1:0]        rem_after;
  logic [LIMIT_W-1:0]      limit_eff;
  logic [LIMIT_W:0]        bytes_inc;
  logic                    ovfl_hit;
  logic                    byte_final;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign slot_free = !out_valid_q || m_axis_tready;
  assign in_sym    = s_axis_tdata[SYM_LSB +: SYM_W];
  assign in_len    = s_axis_tdata[LEN_LSB +: IN_LEN_W];
  assign len_sat   = (in_len > IN_LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                          : LEN_W'(in_len);
  assign code_mask = ~({MAX_CODE_LEN{1'b1}} << len_sat);
  assign in_oob    = {1'b0, in_sym} >= (SYM_W + 1)'(SYMBOL_COUNT);
  assign mem_addr  = in_sym[AW-1:0];
  assign mem_wdata = {len_sat, s_axis_tdata[CODE_LSB +: MAX_CODE_LEN] & code_mask};
  assign mem_we    = in_fire && (s_axis_tuser == CMD_LOAD) && !in_oob;
  assign mem_re    = in_fire && (s_axis_tuser == CMD_ENCODE) && !err_q;

  htenc_ram #(
    .WIDTH (MEM_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  assign rd_len    = rd_valid_q ? mem_rdata[MAX_CODE_LEN +: LEN_W] : '0;
  assign rd_code   = rd_valid_q ? mem_rdata[MAX_CODE_LEN-1:0] : '0;
  assign sh_amt    = SHA_W'(SH_W) - SHA_W'(rd_len) - rem_q;
  assign rem_after = rem_q - SHA_W'(BYTE_W);
  assign limit_eff = (limit_q == '0) ? LIMIT_W'(1) : limit_q;
  assign bytes_inc = {1'b0, bytes_q} + (LIMIT_W + 1)'(1);
  assign ovfl_hit  = bytes_inc >= {1'b0, limit_eff};
  assign byte_final = (rem_after < SHA_W'(BYTE_W)) &&
                      !(last_q && (rem_after != '0));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (mem_re) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (oob_q || (rd_len == '0)) begin
          state_d = ST_FAULT;
        end else begin
          state_d = ST_PACK;
        end
      end
      ST_PACK: begin
        if (rem_q >= SHA_W'(BYTE_W)) begin
          if (slot_free) begin
            if (ovfl_hit) begin
              state_d = ST_FAULT;
            end else if (byte_final) begin
              state_d = ST_IDLE;
            end
          end
        end else if (!(last_q && (rem_q != '0)) || slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_FAULT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    valid_d    = valid_q;
    sh_d       = sh_q;
    rem_d      = rem_q;
    bytes_d    = bytes_q;
    err_d      = err_q;
    last_d     = last_q;
    oob_d      = oob_q;
    rd_valid_d = rd_valid_q;
    fault_d    = fault_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_byte_d  = out_byte_q;
    out_stat_d  = out_stat_q;
    out_eom_d   = out_eom_q;
    out_lor_d   = out_lor_q;

    unique case (state_q)
      ST_IDLE: begin
        if (mem_we) begin
          valid_d[mem_addr] = 1'b1;
        end
        if (in_fire && (s_axis_tuser == CMD_ENCODE)) begin
          last_d     = s_axis_tlast;
          oob_d      = in_oob;
          rd_valid_d = in_oob ? 1'b0 : valid_q[mem_addr];
          if (err_q && s_axis_tlast) begin
            sh_d    = '0;
            rem_d   = '0;
            bytes_d = '0;
            err_d   = 1'b0;
          end
        end
      end
      ST_READ: begin
        if (oob_q || (rd_len == '0)) begin
          fault_d = STAT_UNDEF;
        end else begin
          sh_d  = sh_q | (SH_W'(rd_code) << sh_amt);
          rem_d = rem_q + SHA_W'(rd_len);
        end
      end
      ST_PACK: begin
        if (rem_q >= SHA_W'(BYTE_W)) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_byte_d  = sh_q[SH_W-1 -: BYTE_W];
            out_stat_d  = STAT_BYTE;
            out_lor_d   = !ovfl_hit && byte_final;
            out_eom_d   = !ovfl_hit && byte_final && last_q;
            sh_d        = sh_q << BYTE_W;
            rem_d       = rem_after;
            bytes_d     = bytes_inc[LIMIT_W-1:0];
            if (ovfl_hit) begin
              fault_d = STAT_OVFL;
            end else if (byte_final && last_q) begin
              sh_d    = '0;
              rem_d   = '0;
              bytes_d = '0;
            end
          end
        end else if (last_q) begin
          if (rem_q == '0 || slot_free) begin
            if (rem_q != '0) begin
              out_valid_d = 1'b1;
              out_byte_d  = sh_q[SH_W-1 -: BYTE_W];
              out_stat_d  = STAT_BYTE;
              out_lor_d   = 1'b1;
              out_eom_d   = 1'b1;
            end
            sh_d    = '0;
            rem_d   = '0;
            bytes_d = '0;
          end
        end
      end
      ST_FAULT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = '0;
          out_stat_d  = fault_q;
          out_lor_d   = 1'b1;
          out_eom_d   = last_q;
          sh_d        = '0;
          rem_d       = '0;
          err_d       = !last_q;
          if (last_q) begin
            bytes_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= LIMIT_RESET;
      valid_q     <= '0;
      sh_q        <= '0;
      rem_q       <= '0;
      bytes_q     <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      sh_q        <= sh_d;
      rem_q       <= rem_d;
      bytes_q     <= bytes_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    oob_q      <= oob_d;
    rd_valid_q <= rd_valid_d;
    fault_q    <= fault_d;
    out_byte_q <= out_byte_d;
    out_stat_q <= out_stat_d;
    out_eom_q  <= out_eom_d;
    out_lor_q  <= out_lor_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = {out_eom_q, out_stat_q};
  assign m_axis_tlast  = out_lor_q;

  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q != ST_READ)
    else $error("table read state held longer than one cycle");

  a_idle_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> rem_q < SHA_W'(BYTE_W))
    else $error("whole byte left pending between requests");

  a_fault_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[STATUS_W-1:0] != STAT_BYTE) |-> m_axis_tlast)
    else $error("error status not marked as last result of the request");

  a_no_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && !(out_valid_q && !m_axis_tready) |=> !out_valid_q)
    else $error("result produced without a request in progress");

endmodule

/* hw/rtl/htenc_ram.sv */
module htenc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
